// File: hw/rtl/rgb_to_hsv_pixel_assert.svh
// Assertion macros for the RGB to HSV pixel converter.
`ifndef RGB_TO_HSV_PIXEL_ASSERT_SVH
`define RGB_TO_HSV_PIXEL_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define R2H_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("r2h implication check failed");

// Next-cycle implication, checked out of reset.
`define R2H_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("r2h next-cycle check failed");

`else

`define R2H_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define R2H_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/r2h_pkg.sv
// Shared constants and types for the RGB to HSV pixel converter.
package r2h_pkg;

    localparam int CHANNEL_BITS  = 8;
    localparam int HUE_FRAC_BITS = 6;

    // Hue range is 0 up to below 360 degrees in fractional-degree units
    localparam int HUE_LIMIT = 360 * (2 ** HUE_FRAC_BITS);
    localparam int HUE_BITS  = $clog2(HUE_LIMIT);
    localparam int DEG60     = 60 * (2 ** HUE_FRAC_BITS);
    localparam int CHAN_MAX  = (2 ** CHANNEL_BITS) - 1;

    // Hue numerator: (offset*delta + diff) * 60 deg, below delta * 2^HUE_BITS
    localparam int HUE_NUM_W = CHANNEL_BITS + HUE_BITS;
    localparam int SAT_NUM_W = 2 * CHANNEL_BITS;

    // Divider pipeline: quotient bits spread evenly over the stages
    localparam int DIV_STAGES = 4;
    localparam int HUE_QW     = ((HUE_BITS + DIV_STAGES - 1) / DIV_STAGES) * DIV_STAGES;
    localparam int HUE_STEPS  = HUE_QW / DIV_STAGES;
    localparam int SAT_QW     = ((CHANNEL_BITS + DIV_STAGES - 1) / DIV_STAGES) * DIV_STAGES;
    localparam int SAT_STEPS  = SAT_QW / DIV_STAGES;

    // Request into the divider pipeline
    typedef struct packed {
        logic [HUE_NUM_W-1:0]    hue_num;
        logic [SAT_NUM_W-1:0]    sat_num;
        logic [CHANNEL_BITS-1:0] delta;
        logic [CHANNEL_BITS-1:0] mx;
        logic                    gray;
    } t_div_req;

    // Working state of one divider stage; low fields hold numerator bits
    // still to shift in on top and finished quotient bits below
    typedef struct packed {
        logic [CHANNEL_BITS-1:0] rem_h;
        logic [HUE_QW-1:0]       low_h;
        logic [CHANNEL_BITS-1:0] rem_s;
        logic [SAT_QW-1:0]       low_s;
        logic [CHANNEL_BITS-1:0] delta;
        logic [CHANNEL_BITS-1:0] mx;
        logic                    gray;
    } t_div_st;

endpackage

// File: hw/rtl/r2h_div.sv
// Pipelined restoring divider for the hue and saturation quotients.
module r2h_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  r2h_pkg::t_div_req                i_req,
    output logic                             o_ready,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [r2h_pkg::HUE_BITS-1:0]     o_hue,
    output logic [r2h_pkg::CHANNEL_BITS-1:0] o_saturation,
    output logic [r2h_pkg::CHANNEL_BITS-1:0] o_brightness
);

    localparam int NS = r2h_pkg::DIV_STAGES;
    localparam int CB = r2h_pkg::CHANNEL_BITS;

    r2h_pkg::t_div_st r_st  [NS];
    r2h_pkg::t_div_st n_st  [NS];
    r2h_pkg::t_div_st w_src [NS];
    logic [NS-1:0]    r_vld;
    logic [NS-1:0]    w_vin;
    logic [NS:0]      w_rdy;
    r2h_pkg::t_div_st w_init;

    // Seed: partial remainder is the numerator above the quotient bits
    always_comb begin
        w_init.rem_h = CB'(i_req.hue_num >> r2h_pkg::HUE_QW);
        w_init.low_h = r2h_pkg::HUE_QW'(i_req.hue_num);
        w_init.rem_s = CB'(i_req.sat_num >> r2h_pkg::SAT_QW);
        w_init.low_s = r2h_pkg::SAT_QW'(i_req.sat_num);
        w_init.delta = i_req.delta;
        w_init.mx    = i_req.mx;
        w_init.gray  = i_req.gray;
    end

    // A stage takes a new request when empty or when the next one moves
    assign w_rdy[NS] = !i_stall;
    assign o_ready   = w_rdy[0];
    assign w_src[0]  = w_init;
    assign w_vin[0]  = i_valid;

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [CB:0] acc_h;
        logic [CB:0] acc_s;

        if (k > 0) begin : g_link
            assign w_src[k] = r_st[k-1];
            assign w_vin[k] = r_vld[k-1];
        end

        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];

        // A few quotient bits per stage for each lane
        always_comb begin
            n_st[k] = w_src[k];
            acc_h   = '0;
            acc_s   = '0;
            for (int s = 0; s < r2h_pkg::HUE_STEPS; s++) begin
                acc_h = {n_st[k].rem_h, n_st[k].low_h[r2h_pkg::HUE_QW-1]};
                n_st[k].low_h = {n_st[k].low_h[r2h_pkg::HUE_QW-2:0], 1'b0};
                if (acc_h >= {1'b0, n_st[k].delta}) begin
                    n_st[k].rem_h    = CB'(acc_h - {1'b0, n_st[k].delta});
                    n_st[k].low_h[0] = 1'b1;
                end else begin
                    n_st[k].rem_h = acc_h[CB-1:0];
                end
            end
            for (int s = 0; s < r2h_pkg::SAT_STEPS; s++) begin
                acc_s = {n_st[k].rem_s, n_st[k].low_s[r2h_pkg::SAT_QW-1]};
                n_st[k].low_s = {n_st[k].low_s[r2h_pkg::SAT_QW-2:0], 1'b0};
                if (acc_s >= {1'b0, n_st[k].mx}) begin
                    n_st[k].rem_s    = CB'(acc_s - {1'b0, n_st[k].mx});
                    n_st[k].low_s[0] = 1'b1;
                end else begin
                    n_st[k].rem_s = acc_s[CB-1:0];
                end
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (w_rdy[k] && w_vin[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // Gray or black pixel forces hue and saturation to zero
    assign o_valid      = r_vld[NS-1];
    assign o_hue        = r_st[NS-1].gray ? '0 : r_st[NS-1].low_h[r2h_pkg::HUE_BITS-1:0];
    assign o_saturation = r_st[NS-1].gray ? '0 : r_st[NS-1].low_s[CB-1:0];
    assign o_brightness = r_st[NS-1].mx;

endmodule

// File: hw/rtl/rgb_to_hsv_pixel.sv
// RGB to HSV pixel converter top level.
//
// Input channel: i_valid / o_stall with i_red, i_green, i_blue. A pixel is
// taken at a clock edge where i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with o_hue (1/64 degree), o_saturation
// and o_brightness. A result moves at an edge with o_valid high and
// i_stall low.
// Throughput: one pixel per clock while i_stall stays low. A result passes
// through two front stages (max/min and sector, then numerators) and four
// divider stages that each resolve a quarter of the quotient bits.
// Each stage holds its own valid bit and advances when empty or when the
// stage after it moves, so bubbles close up under a stall.
// While i_stall is high the last stage holds its result steady; o_stall
// rises only once every stage is full. Nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous) clears all valid bits; there is no
// other state.
`include "rgb_to_hsv_pixel_assert.svh"

module rgb_to_hsv_pixel (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [r2h_pkg::CHANNEL_BITS-1:0] i_red,
    input  logic [r2h_pkg::CHANNEL_BITS-1:0] i_green,
    input  logic [r2h_pkg::CHANNEL_BITS-1:0] i_blue,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [r2h_pkg::HUE_BITS-1:0]     o_hue,
    output logic [r2h_pkg::CHANNEL_BITS-1:0] o_saturation,
    output logic [r2h_pkg::CHANNEL_BITS-1:0] o_brightness
);

    localparam int CB = r2h_pkg::CHANNEL_BITS;
    localparam int NW = r2h_pkg::HUE_NUM_W;
    localparam int SW = r2h_pkg::SAT_NUM_W;

    // Sector offsets in units of 60 degrees
    localparam logic [2:0] OFS_RED   = 3'd0;
    localparam logic [2:0] OFS_WRAP  = 3'd6;
    localparam logic [2:0] OFS_GREEN = 3'd2;
    localparam logic [2:0] OFS_BLUE  = 3'd4;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // Stage 1 registers
    logic                r1_vld;
    logic [CB-1:0]       r1_mx;
    logic [CB-1:0]       r1_delta;
    logic signed [CB:0]  r1_diff;
    t_sector             r1_sec;
    // Stage 2 registers
    logic                r2_vld;
    r2h_pkg::t_div_req   r2_req;

    logic [CB-1:0]       n1_mx;
    logic [CB-1:0]       n1_mn;
    logic signed [CB:0]  n1_diff;
    t_sector             n1_sec;
    logic [2:0]          w_ofs;
    logic [CB+3:0]       w_t;
    r2h_pkg::t_div_req   n2_req;
    logic                w_rdy1;
    logic                w_rdy2;
    logic                w_div_rdy;

    // Handshake between stages
    assign w_rdy2  = !r2_vld || w_div_rdy;
    assign w_rdy1  = !r1_vld || w_rdy2;
    assign o_stall = !w_rdy1;

    // Stage 1: max, min, sector and signed channel difference
    always_comb begin
        n1_mx = (i_red >= i_green) ? i_red : i_green;
        n1_mx = (n1_mx >= i_blue) ? n1_mx : i_blue;
        n1_mn = (i_red <= i_green) ? i_red : i_green;
        n1_mn = (n1_mn <= i_blue) ? n1_mn : i_blue;
        if (i_red >= i_green && i_red >= i_blue) begin
            n1_sec  = SEC_RED;
            n1_diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (i_green >= i_blue) begin
            n1_sec  = SEC_GREEN;
            n1_diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            n1_sec  = SEC_BLUE;
            n1_diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end
    end

    // Stage 2: hue numerator (ofs*delta + diff)*60deg, saturation numerator
    always_comb begin
        case (r1_sec)
            SEC_RED:   w_ofs = r1_diff[CB] ? OFS_WRAP : OFS_RED;
            SEC_GREEN: w_ofs = OFS_GREEN;
            SEC_BLUE:  w_ofs = OFS_BLUE;
            default:   w_ofs = OFS_RED;
        endcase
        // two's-complement add; the sum is never negative
        w_t = {{3{r1_diff[CB]}}, r1_diff}
            + {1'b0, (CB + 3)'(w_ofs) * (CB + 3)'(r1_delta)};
        n2_req.hue_num = NW'(w_t[CB+2:0]) * NW'(r2h_pkg::DEG60);
        n2_req.sat_num = SW'(r1_delta) * SW'(r2h_pkg::CHAN_MAX);
        n2_req.delta   = r1_delta;
        n2_req.mx      = r1_mx;
        n2_req.gray    = (r1_delta == '0);
    end

    // Front valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r1_vld <= i_valid;
            end
            if (w_rdy2) begin
                r2_vld <= r1_vld;
            end
        end
    end

    // Front payload
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r1_mx    <= n1_mx;
            r1_delta <= n1_mx - n1_mn;
            r1_diff  <= n1_diff;
            r1_sec   <= n1_sec;
        end
        if (w_rdy2 && r1_vld) begin
            r2_req <= n2_req;
        end
    end

    r2h_div u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r2_vld),
        .i_req        (r2_req),
        .o_ready      (w_div_rdy),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

    // Checks
    `R2H_ASSERT_IMPLY(a_hue_range, i_clk, i_rst_n, o_valid, o_hue < r2h_pkg::HUE_BITS'(r2h_pkg::HUE_LIMIT))
    `R2H_ASSERT_IMPLY(a_black_zero, i_clk, i_rst_n, o_valid && o_brightness == '0, o_saturation == '0 && o_hue == '0)
    `R2H_ASSERT_IMPLY(a_stall_full, i_clk, i_rst_n, o_stall, r1_vld && r2_vld && o_valid)
    `R2H_ASSERT_NEXT(a_front_hold, i_clk, i_rst_n, r2_vld && !w_div_rdy, r2_vld && $stable(r2_req))

endmodule

// File: bench/hsv_checker.sv
// Checker for the RGB to HSV converter: predicts each result and compares it.
module hsv_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [r2h_pkg::CHANNEL_BITS-1:0] i_red,
    input  logic [r2h_pkg::CHANNEL_BITS-1:0] i_green,
    input  logic [r2h_pkg::CHANNEL_BITS-1:0] i_blue,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic [r2h_pkg::HUE_BITS-1:0]     i_hue,
    input  logic [r2h_pkg::CHANNEL_BITS-1:0] i_saturation,
    input  logic [r2h_pkg::CHANNEL_BITS-1:0] i_brightness,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRINTED = 30;

    typedef struct packed {
        logic [r2h_pkg::HUE_BITS-1:0]     hue;
        logic [r2h_pkg::CHANNEL_BITS-1:0] sat;
        logic [r2h_pkg::CHANNEL_BITS-1:0] val;
    } t_hsv;

    t_hsv hsv_q[$];
    t_hsv want;
    int   fails   = 0;
    int   checked = 0;

    // Hexcone conversion on exact integers; every division truncates
    function automatic t_hsv hsv_of(input logic [r2h_pkg::CHANNEL_BITS-1:0] r,
                                    input logic [r2h_pkg::CHANNEL_BITS-1:0] g,
                                    input logic [r2h_pkg::CHANNEL_BITS-1:0] b);
        longint rr, gg, bb, mx, mn, delta, num;
        t_hsv   res;
        rr = r;
        gg = g;
        bb = b;
        mx = (rr > gg) ? rr : gg;
        mx = (mx > bb) ? mx : bb;
        mn = (rr < gg) ? rr : gg;
        mn = (mn < bb) ? mn : bb;
        delta = mx - mn;
        if (delta == 0) begin
            res.hue = '0;
        end else begin
            // ties: red sector wins, then green
            if (mx == rr) begin
                num = longint'(r2h_pkg::DEG60) * (gg - bb);
                if (num < 0) num += longint'(r2h_pkg::HUE_LIMIT) * delta;
            end else if (mx == gg) begin
                num = longint'(r2h_pkg::DEG60) * (bb - rr)
                    + 2 * longint'(r2h_pkg::DEG60) * delta;
            end else begin
                num = longint'(r2h_pkg::DEG60) * (rr - gg)
                    + 4 * longint'(r2h_pkg::DEG60) * delta;
            end
            res.hue = r2h_pkg::HUE_BITS'(num / delta);
        end
        res.sat = (mx == 0) ? '0
                            : r2h_pkg::CHANNEL_BITS'((delta * r2h_pkg::CHAN_MAX) / mx);
        res.val = r2h_pkg::CHANNEL_BITS'(mx);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        fails++;
        if (fails <= MAX_PRINTED)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, exp_val);
    endtask

    // Results retire the oldest prediction; accepted requests add one
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (hsv_q.size() == 0) begin
                    report_mismatch("result with nothing pending", i_hue, 0);
                end else begin
                    want = hsv_q.pop_front();
                    checked++;
                    if (i_hue !== want.hue) report_mismatch("hue", i_hue, want.hue);
                    if (i_saturation !== want.sat)
                        report_mismatch("saturation", i_saturation, want.sat);
                    if (i_brightness !== want.val)
                        report_mismatch("brightness", i_brightness, want.val);
                end
            end
            if (i_in_valid && !i_in_stall) hsv_q.push_back(hsv_of(i_red, i_green, i_blue));
        end
        o_fail_count <= fails;
        o_pending    <= hsv_q.size();
        o_checked    <= checked;
    end

endmodule

// File: bench/tb.sv
// Testbench top for the RGB to HSV converter: stimulus, flow control and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PIXELS = 1030;
    localparam int HOLD_AT       = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 12;

    typedef logic [r2h_pkg::CHANNEL_BITS-1:0] t_chan;

    logic                         i_clk        = 1'b0;
    logic                         i_rst_n      = 1'b0;
    logic                         i_valid      = 1'b0;
    logic                         i_stall      = 1'b0;
    t_chan                        i_red        = '0;
    t_chan                        i_green      = '0;
    t_chan                        i_blue       = '0;
    logic                         o_stall;
    logic                         o_valid;
    logic [r2h_pkg::HUE_BITS-1:0] o_hue;
    t_chan                        o_saturation;
    t_chan                        o_brightness;

    int fail_count;
    int pending;
    int checked;
    int sent_count     = 0;
    int directed_count = 0;
    int cycles         = 0;
    int backpressure   = 0;
    bit hold_done      = 1'b0;

    rgb_to_hsv_pixel dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

    hsv_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_hue        (o_hue),
        .i_saturation (o_saturation),
        .i_brightness (o_brightness),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog and count of cycles the block pushed back on the sender
    always @(posedge i_clk) begin
        cycles++;
        if (i_valid && o_stall) backpressure++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones, and stretches with none at all
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if ((sent_count / 150) % 4 == 1) return 0;
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one request, hold it until taken, then maybe idle
    task automatic send_pixel(input t_chan r, input t_chan g, input t_chan b);
        int gap;
        i_valid <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_count++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            i_red   <= t_chan'($urandom);
            i_green <= t_chan'($urandom);
            i_blue  <= t_chan'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Random pixel shaped toward grays, ties, near-wrap hues and extremes
    task automatic random_pixel(output t_chan r, output t_chan g, output t_chan b);
        int    kind;
        t_chan base;
        kind = $urandom_range(0, 9);
        r = t_chan'($urandom);
        g = t_chan'($urandom);
        b = t_chan'($urandom);
        base = t_chan'($urandom);
        case (kind)
            4: begin
                g = r;
                b = r;
            end
            5: begin
                case ($urandom_range(0, 2))
                    0: begin g = r; b = t_chan'($urandom_range(0, r)); end
                    1: begin b = g; r = t_chan'($urandom_range(0, g)); end
                    default: begin b = r; g = t_chan'($urandom_range(0, r)); end
                endcase
            end
            6: begin
                base = t_chan'($urandom_range(0, r2h_pkg::CHAN_MAX - 2));
                r = base + t_chan'($urandom_range(0, 2));
                g = base + t_chan'($urandom_range(0, 2));
                b = base + t_chan'($urandom_range(0, 2));
            end
            7: begin
                r = $urandom_range(0, 1) ? t_chan'($urandom_range(0, 1))
                    : t_chan'(r2h_pkg::CHAN_MAX - $urandom_range(0, 1));
                g = $urandom_range(0, 1) ? t_chan'($urandom_range(0, 1))
                    : t_chan'(r2h_pkg::CHAN_MAX - $urandom_range(0, 1));
                b = $urandom_range(0, 1) ? t_chan'($urandom_range(0, 1))
                    : t_chan'(r2h_pkg::CHAN_MAX - $urandom_range(0, 1));
            end
            8: begin
                // red on top, blue above green: hue between 300 and 360
                r = t_chan'($urandom_range(2, r2h_pkg::CHAN_MAX));
                g = t_chan'($urandom_range(0, r - 2));
                b = g + t_chan'($urandom_range(1, r - g - 1));
            end
            9: begin
                case ($urandom_range(0, 2))
                    0: r = '0;
                    1: g = '0;
                    default: b = '0;
                endcase
            end
            default: begin
            end
        endcase
    endtask

    // Receiver: random stall runs, quiet stretches, and one long hold-off
    initial begin
        int run;
        int hold_left;
        int mode;
        run = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            mode = (cycles / 250) % 4;
            if (!hold_done && sent_count >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
                run = 0;
            end else if (run > 0) begin
                run--;
            end else if (mode == 0) begin
                i_stall <= 1'b0;
                run = $urandom_range(5, 20);
            end else begin
                i_stall <= ($urandom_range(0, 99) < 35);
                run = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3)
                                                   : $urandom_range(10, 40);
            end
        end
    end

    // Stimulus, drain and verdict
    initial begin
        t_chan directed[$][3];
        t_chan r, g, b;
        directed = '{
            '{8'd0,   8'd0,   8'd0},     // black
            '{8'd255, 8'd255, 8'd255},   // white
            '{8'd128, 8'd128, 8'd128},   // gray
            '{8'd1,   8'd1,   8'd1},
            '{8'd255, 8'd0,   8'd0},     // primaries
            '{8'd0,   8'd255, 8'd0},
            '{8'd0,   8'd0,   8'd255},
            '{8'd255, 8'd255, 8'd0},     // red/green tie
            '{8'd0,   8'd255, 8'd255},   // green/blue tie
            '{8'd255, 8'd0,   8'd255},   // red/blue tie, wraps
            '{8'd255, 8'd0,   8'd1},     // just below zero degrees
            '{8'd255, 8'd254, 8'd255},
            '{8'd1,   8'd0,   8'd0},
            '{8'd0,   8'd0,   8'd1},
            '{8'd0,   8'd1,   8'd0},
            '{8'd255, 8'd0,   8'd254},
            '{8'd254, 8'd255, 8'd0},
            '{8'd85,  8'd170, 8'd255},
            '{8'd170, 8'd85,  8'd15},
            '{8'd200, 8'd10,  8'd199},
            '{8'd37,  8'd241, 8'd3}
        };
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_pixel(directed[k][0], directed[k][1], directed[k][2]);
            directed_count++;
        end
        repeat (RANDOM_PIXELS) begin
            random_pixel(r, g, b);
            send_pixel(r, g, b);
        end
        i_valid <= 1'b0;

        // pending count is a registered copy of the checker's queue size
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d pixels sent (%0d directed), %0d results compared", sent_count,
                 directed_count, checked);
        $display("tb: sender held off by the block for %0d cycles, %0d mismatches",
                 backpressure, fail_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/r2h_pkg.sv
hw/rtl/r2h_div.sv
hw/rtl/rgb_to_hsv_pixel.sv
bench/hsv_checker.sv
bench/tb.sv
